FILE: rtl/msgm_pkg.sv
// Package: shared types, constants and address helper for the gap-method merge.
`timescale 1ns / 1ps

package msgm_pkg;

  localparam int CAPACITY = 64;
  localparam int AW       = $clog2(CAPACITY);   // store address width
  localparam int CW       = $clog2(CAPACITY + 1); // element count width
  localparam int DW       = 32;
  localparam int PW       = 6;                  // position field width

  typedef struct packed {
    logic signed [DW-1:0] value;
    logic                 in_second;
    logic                 last;
  } item_t;

  typedef struct packed {
    logic signed [DW-1:0] value_res;
    logic                 in_second_res;
    logic [PW-1:0]        position;
    logic                 overflow;
    logic                 end_of_run;
  } result_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SETUP,
    S_READ,
    S_CMP,
    S_SWAP,
    S_EMIT,
    S_FLUSH
  } state_t;

  // First array grows up from entry 0, second array grows down from the top entry.
  function automatic logic [AW-1:0] seq_addr(input logic [AW-1:0] k,
                                             input logic [CW-1:0] m);
    logic [CW-1:0] kk;
    logic [CW-1:0] off;
    logic [CW-1:0] top;
    kk  = {1'b0, k};
    off = kk - m;
    top = CW'(CAPACITY - 1) - off;
    if (kk < m) begin
      return k;
    end else begin
      return top[AW-1:0];
    end
  endfunction

endpackage

FILE: rtl/msgm_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps

module msgm_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re_a,
  input  logic [ADDR_W-1:0] raddr_a,
  output logic [DATA_W-1:0] rdata_a,
  input  logic              re_b,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data until the next read on that port
  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: rtl/merge_sorted_gap_method.sv
// Top level: load, gap-method merge over the element store, ordered emit.
`timescale 1ns / 1ps

// Words are loaded one per cycle while busy is low; the second array is kept
// at the top of the 64-entry store, growing downward. The word marked last
// closes the batch and raises busy. The merge then runs passes at gap
// ceil(len/2), halving with round-up down to 1; each pass visits len-gap
// pairs, each read in S_READ and compared in S_CMP, plus an S_SWAP step for a
// swapped pair, because both elements come through the store's two read
// ports and go back through its single write port. S_READ steps the gap at
// the end of each pass. The emit phase gives one result per cycle with strobe
// high for exactly that cycle; the receiver cannot stall, so results must be
// taken as they appear. Busy falls in the cycle after the end_of_run word.
// Words arriving while the store is full are dropped and flagged in overflow.
module merge_sorted_gap_method (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  msgm_pkg::item_t  item,
  output msgm_pkg::result_t result,
  output logic             strobe
);

  import msgm_pkg::*;

  state_t        state, state_next;
  logic [CW-1:0] first_count, first_count_next;
  logic [CW-1:0] second_count, second_count_next;
  logic          dropped, dropped_next;
  logic [AW-1:0] gap, gap_next;
  logic [AW-1:0] lo, lo_next;
  logic [AW-1:0] addr_lo, addr_lo_next;
  logic [AW-1:0] addr_hi, addr_hi_next;
  logic [AW-1:0] k, k_next;

  // emit stage tags, aligned with the read data
  logic          stg_valid, stg_valid_next;
  logic          stg_second, stg_second_next;
  logic [PW-1:0] stg_pos, stg_pos_next;
  logic          stg_end, stg_end_next;

  logic          we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic          re_a, re_b;
  logic [AW-1:0] raddr_a, raddr_b;
  logic [DW-1:0] rdata_a, rdata_b;

  logic [CW-1:0] len;
  logic [CW-1:0] hi_sum;
  logic [CW:0]   len_up;
  logic [AW:0]   gap_up;
  logic [CW-1:0] k_ext;
  logic [CW-1:0] k_rel;
  logic [CW-1:0] top_free;
  logic          accept;
  logic          room;

  assign len      = first_count + second_count;
  assign hi_sum   = CW'(lo) + CW'(gap);
  assign len_up   = {1'b0, len} + (CW+1)'(1);
  assign gap_up   = {1'b0, gap} + (AW+1)'(1);
  assign k_ext    = {1'b0, k};
  assign k_rel    = k_ext - first_count;
  assign top_free = CW'(CAPACITY - 1) - second_count;
  assign accept   = start && !busy;
  assign room     = len < CW'(CAPACITY);

  msgm_ram #(
    .DATA_W (DW),
    .ADDR_W (AW)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re_a    (re_a),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .re_b    (re_b),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      first_count  <= '0;
      second_count <= '0;
      dropped      <= 1'b0;
      stg_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      first_count  <= first_count_next;
      second_count <= second_count_next;
      dropped      <= dropped_next;
      stg_valid    <= stg_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    gap        <= gap_next;
    lo         <= lo_next;
    addr_lo    <= addr_lo_next;
    addr_hi    <= addr_hi_next;
    k          <= k_next;
    stg_second <= stg_second_next;
    stg_pos    <= stg_pos_next;
    stg_end    <= stg_end_next;
  end

  always_comb begin
    state_next        = state;
    first_count_next  = first_count;
    second_count_next = second_count;
    dropped_next      = dropped;
    gap_next          = gap;
    lo_next           = lo;
    addr_lo_next      = addr_lo;
    addr_hi_next      = addr_hi;
    k_next            = k;
    stg_valid_next    = 1'b0;
    stg_second_next   = stg_second;
    stg_pos_next      = stg_pos;
    stg_end_next      = stg_end;
    we                = 1'b0;
    waddr             = addr_lo;
    wdata             = rdata_b;
    re_a              = 1'b0;
    re_b              = 1'b0;
    raddr_a           = seq_addr(lo, first_count);
    raddr_b           = seq_addr(hi_sum[AW-1:0], first_count);
    busy              = 1'b1;

    unique case (state)
      S_LOAD: begin
        busy = 1'b0;
        if (accept) begin
          if (room) begin
            we    = 1'b1;
            wdata = item.value;
            if (item.in_second) begin
              waddr             = top_free[AW-1:0];
              second_count_next = second_count + CW'(1);
            end else begin
              waddr            = first_count[AW-1:0];
              first_count_next = first_count + CW'(1);
            end
          end else begin
            dropped_next = 1'b1;
          end
          if (item.last) begin
            state_next = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        gap_next   = len_up[CW:1] > CW'(0) ? len_up[AW:1] : '0;
        lo_next    = '0;
        state_next = S_READ;
      end
      S_READ: begin
        if (hi_sum < len) begin
          re_a         = 1'b1;
          re_b         = 1'b1;
          addr_lo_next = raddr_a;
          addr_hi_next = raddr_b;
          state_next   = S_CMP;
        end else if (gap == AW'(1)) begin
          k_next     = '0;
          state_next = S_EMIT;
        end else begin
          gap_next = gap_up[AW:1];
          lo_next  = '0;
        end
      end
      S_CMP: begin
        if ($signed(rdata_a) > $signed(rdata_b)) begin
          // lower entry takes the smaller value now, upper entry next cycle
          we         = 1'b1;
          waddr      = addr_lo;
          wdata      = rdata_b;
          state_next = S_SWAP;
        end else begin
          lo_next    = lo + AW'(1);
          state_next = S_READ;
        end
      end
      S_SWAP: begin
        we         = 1'b1;
        waddr      = addr_hi;
        wdata      = rdata_a;
        lo_next    = lo + AW'(1);
        state_next = S_READ;
      end
      S_EMIT: begin
        re_a           = 1'b1;
        raddr_a        = seq_addr(k, first_count);
        stg_valid_next = 1'b1;
        stg_second_next = k_ext >= first_count;
        stg_pos_next   = (k_ext >= first_count) ? k_rel[PW-1:0] : k_ext[PW-1:0];
        stg_end_next   = (k_ext + CW'(1)) == len;
        k_next         = k + AW'(1);
        if ((k_ext + CW'(1)) == len) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        // last result is on the ports this cycle; empty the batch
        first_count_next  = '0;
        second_count_next = '0;
        dropped_next      = 1'b0;
        state_next        = S_LOAD;
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  assign strobe               = stg_valid;
  assign result.value_res     = rdata_a;
  assign result.in_second_res = stg_second;
  assign result.position      = stg_pos;
  assign result.overflow      = dropped;
  assign result.end_of_run    = stg_end;

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result strobe outside of a busy phase");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.end_of_run) |=> (!strobe && !busy))
    else $error("block not idle after the last word of a run");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    (first_count + second_count) <= CW'(CAPACITY))
    else $error("element count beyond store capacity");

  a_swap_follow: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWAP) |-> $past(state == S_CMP))
    else $error("swap write without a compare");

endmodule

FILE: test/tb_top.sv
// Testbench: gap-method merge checked word by word against an in-bench predictor.
`timescale 1ns / 1ps

module tb_top;
  import msgm_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_WORDS = 420;
  localparam int TAIL_CYCLES = 30;
  localparam logic signed [DW-1:0] VMIN = 32'sh8000_0000;
  localparam logic signed [DW-1:0] VMAX = 32'sh7FFF_FFFF;

  typedef struct {
    item_t word;
    bit    single; // one-word batch: the word comes back as is
  } dir_row_t;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  item_t   item;
  result_t result;
  logic    strobe;

  int      held_first[$];
  int      held_second[$];
  bit      dropped;
  result_t due_results[$];
  result_t want;
  dir_row_t dir_rows[$];
  int      errors = 0;
  int      cycles = 0;

  merge_sorted_gap_method u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .result (result),
    .strobe (strobe)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d words still due", $time, due_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // Store a word; on the batch's last word run the gap passes and, if keep is set, queue the merged words.
  task automatic absorb_word(input item_t w, input bit keep);
    int seq[$];
    int m;
    int len;
    int gap;
    int lo;
    int tmp;
    result_t r;
    if (held_first.size() + held_second.size() < CAPACITY) begin
      if (w.in_second) held_second.push_back(w.value);
      else held_first.push_back(w.value);
    end else begin
      dropped = 1'b1;
    end
    if (!w.last) return;
    m = held_first.size();
    len = m + held_second.size();
    foreach (held_first[k]) seq.push_back(held_first[k]);
    foreach (held_second[k]) seq.push_back(held_second[k]);
    gap = (len + 1) / 2;
    while (len > 0) begin
      for (lo = 0; lo + gap < len; lo++) begin
        if (seq[lo] > seq[lo + gap]) begin
          tmp = seq[lo];
          seq[lo] = seq[lo + gap];
          seq[lo + gap] = tmp;
        end
      end
      if (gap == 1) break;
      gap = (gap + 1) / 2;
    end
    for (int k = 0; k < len; k++) begin
      r.value_res     = seq[k];
      r.in_second_res = (k >= m);
      r.position      = PW'((k >= m) ? k - m : k);
      r.overflow      = dropped;
      r.end_of_run    = (k == len - 1);
      if (keep) due_results.push_back(r);
    end
    held_first.delete();
    held_second.delete();
    dropped = 1'b0;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Called at a falling edge; returns at a falling edge after the word and its gap.
  task automatic send_word(input item_t w, input int idle, input bit keep);
    start = 1'b1;
    item  = w;
    @(posedge clk);
    while (busy) @(posedge clk);
    absorb_word(w, keep);
    @(negedge clk);
    if (idle > 0) begin
      start = 1'b0;
      repeat (idle) @(negedge clk);
    end
  endtask

  task automatic drain();
    start = 1'b0;
    while (due_results.size() != 0) @(negedge clk);
  endtask

  task automatic add_row(input logic [DW-1:0] v, input bit sec, input bit lst,
                         input bit single);
    dir_row_t row;
    row.word.value     = v;
    row.word.in_second = sec;
    row.word.last      = lst;
    row.single         = single;
    dir_rows.push_back(row);
  endtask

  // Two arrays, each ascending unless noisy, interleaved at random.
  task automatic send_batch(input int n, input bit noisy, input bit steady);
    int firsts[$];
    int seconds[$];
    int n1;
    int cnt;
    int f;
    int s;
    longint acc;
    longint span;
    int v;
    item_t w;
    n1 = $urandom_range(0, n);
    for (int a = 0; a < 2; a++) begin
      cnt = a ? n - n1 : n1;
      case ($urandom_range(0, 3))
        0: span = 2;
        1: span = 1000;
        2: span = 64'h0400_0000;
        default: span = 64'hFFFF_FFFF;
      endcase
      if ($urandom_range(0, 3) == 0) acc = longint'(VMIN) + $urandom_range(0, 3);
      else acc = longint'(int'($urandom));
      for (int i = 0; i < cnt; i++) begin
        if (noisy) begin
          v = int'($urandom);
        end else begin
          if (i > 0) acc = acc + longint'($urandom_range(0, 32'(span)));
          if (acc > longint'(VMAX)) acc = longint'(VMAX);
          v = int'(acc);
        end
        if (a) seconds.push_back(v);
        else firsts.push_back(v);
      end
    end
    f = 0;
    s = 0;
    for (int i = 0; i < n; i++) begin
      if (f == n1 || (s < n - n1 && $urandom_range(0, 1) == 1)) begin
        w.value = seconds[s];
        w.in_second = 1'b1;
        s++;
      end else begin
        w.value = firsts[f];
        w.in_second = 1'b0;
        f++;
      end
      w.last = (i == n - 1);
      send_word(w, steady ? 0 : pick_gap(), 1'b1);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t unexpected word: expected none, actual %h", $time, result);
      end else begin
        want = due_results.pop_front();
        if (result.value_res !== want.value_res) begin
          errors++;
          $display("%0t value_res: expected %0d, actual %0d", $time,
                   want.value_res, result.value_res);
        end
        if (result.in_second_res !== want.in_second_res) begin
          errors++;
          $display("%0t in_second_res: expected %b, actual %b", $time,
                   want.in_second_res, result.in_second_res);
        end
        if (result.position !== want.position) begin
          errors++;
          $display("%0t position: expected %0d, actual %0d", $time,
                   want.position, result.position);
        end
        if (result.overflow !== want.overflow) begin
          errors++;
          $display("%0t overflow: expected %b, actual %b", $time,
                   want.overflow, result.overflow);
        end
        if (result.end_of_run !== want.end_of_run) begin
          errors++;
          $display("%0t end_of_run: expected %b, actual %b", $time,
                   want.end_of_run, result.end_of_run);
        end
      end
    end
  end

  initial begin
    int sent;
    int batch;
    int n;
    int r;
    result_t lit;
    rst   = 1'b1;
    start = 1'b0;
    item  = '0;
    dropped = 1'b0;

    // single-word batches at the extremes, at zero and at all ones
    add_row(VMIN, 1'b0, 1'b1, 1'b1);
    add_row(VMAX, 1'b1, 1'b1, 1'b1);
    add_row(32'd0, 1'b0, 1'b1, 1'b1);
    add_row(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
    // second array arrives first, ties across arrays
    add_row(-32'sd3, 1'b1, 1'b0, 1'b0);
    add_row(32'd5, 1'b0, 1'b0, 1'b0);
    add_row(32'd9, 1'b1, 1'b0, 1'b0);
    add_row(32'd9, 1'b0, 1'b1, 1'b0);
    // empty first array
    add_row(VMIN, 1'b1, 1'b0, 1'b0);
    add_row(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
    add_row(VMAX, 1'b1, 1'b1, 1'b0);
    // first array out of order
    add_row(VMAX, 1'b0, 1'b0, 1'b0);
    add_row(32'd0, 1'b0, 1'b0, 1'b0);
    add_row(VMIN, 1'b0, 1'b0, 1'b0);
    add_row(32'd7, 1'b1, 1'b1, 1'b0);
    // full span in both arrays
    add_row(VMIN, 1'b0, 1'b0, 1'b0);
    add_row(VMIN, 1'b1, 1'b0, 1'b0);
    add_row(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
    add_row(32'd0, 1'b0, 1'b0, 1'b0);
    add_row(32'd1, 1'b0, 1'b0, 1'b0);
    add_row(VMAX, 1'b1, 1'b0, 1'b0);
    add_row(VMAX, 1'b0, 1'b1, 1'b0);
    // alternating bit patterns
    add_row(32'h5555_5555, 1'b0, 1'b0, 1'b0);
    add_row(32'hAAAA_AAAA, 1'b1, 1'b1, 1'b0);

    repeat (10) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].single) begin
        lit.value_res     = dir_rows[i].word.value;
        lit.in_second_res = dir_rows[i].word.in_second;
        lit.position      = '0;
        lit.overflow      = 1'b0;
        lit.end_of_run    = 1'b1;
        due_results.push_back(lit);
      end
      send_word(dir_rows[i].word, pick_gap(), !dir_rows[i].single);
    end

    // hold off until the directed words have all come back
    drain();

    sent = 0;
    batch = 0;
    while (sent < RANDOM_WORDS) begin
      case (batch)
        0: n = CAPACITY;          // exactly full
        1: n = CAPACITY + 1;      // last word dropped
        2: n = CAPACITY + 6;
        default: begin
          r = $urandom_range(0, 99);
          if (r < 70) n = $urandom_range(1, 8);
          else if (r < 90) n = $urandom_range(9, 24);
          else if (r < 97) n = $urandom_range(25, CAPACITY);
          else n = $urandom_range(CAPACITY + 1, CAPACITY + 8);
        end
      endcase
      send_batch(n, $urandom_range(0, 9) == 0, $urandom_range(0, 3) == 0);
      sent += n;
      batch++;
      if (batch == 20) drain();
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0 && due_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/msgm_pkg.sv
rtl/msgm_ram.sv
rtl/merge_sorted_gap_method.sv
test/tb_top.sv
